@@ src/fpaf_pkg.sv @@
// shared types, constants and formatting functions for the fixed-point ascii formatter
package fpaf_pkg;

   // widths
   localparam int VALUE_W   = 32;
   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int POS_W     = 3;
   localparam int FIELD_LEN = 6;
   localparam int BIN_W     = 17;
   localparam int DIGITS    = 5;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int CHAIN_LEN = BIN_W;

   // format modes
   localparam logic [MODE_W-1:0] MODE_UDEC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SDEC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UBIN = 2'd2;

   // range limits
   localparam logic [VALUE_W-1:0] UDEC_MAX   = 32'd99999;
   localparam logic [VALUE_W-1:0] SDEC_MAX   = 32'd9999;
   localparam logic [VALUE_W-1:0] UBIN_LIMIT = 32'd256000;

   // binary mode scaling
   localparam logic [BIN_W-1:0] UBIN_INT_SCALE = 17'd100;
   localparam logic [6:0]       FRAC_SCALE     = 7'd100;

   // character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;

   typedef logic [CHAR_W-1:0] char_type;
   typedef char_type [FIELD_LEN-1:0] field_type;

   // word travelling down the conversion chain
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
      logic             ovf;
      logic             neg;
      logic             sdec;
   } cell_data_type;

   // one shift-and-add-3 step of the binary to bcd conversion
   function automatic cell_data_type dabble_step(input cell_data_type d);
      cell_data_type    r;
      logic [BCD_W-1:0] adj;
      logic [3:0]       dig;
      r   = d;
      adj = d.bcd;
      for (int i = 0; i < DIGITS; i++) begin
         dig = d.bcd[4*i +: 4];
         if (dig >= 4'd5) begin
            adj[4*i +: 4] = dig + 4'd3;
         end
      end
      r.bcd = {adj[BCD_W-2:0], d.bin[BIN_W-1]};
      r.bin = {d.bin[BIN_W-2:0], 1'b0};
      return r;
   endfunction

   function automatic char_type digit_char(input logic [3:0] dig);
      return CH_ZERO + {4'd0, dig};
   endfunction

   // six characters from the converted digits
   function automatic field_type format_field(input cell_data_type d);
      field_type             f;
      logic [DIGITS-1:0][3:0] dg;
      dg = d.bcd;
      if (d.sdec) begin
         if (d.ovf) begin
            f[0] = CH_BLANK;
            f[1] = CH_STAR;
            f[2] = CH_POINT;
            f[3] = CH_STAR;
            f[4] = CH_STAR;
            f[5] = CH_STAR;
         end else begin
            f[0] = d.neg ? CH_MINUS : CH_BLANK;
            f[1] = digit_char(dg[3]);
            f[2] = CH_POINT;
            f[3] = digit_char(dg[2]);
            f[4] = digit_char(dg[1]);
            f[5] = digit_char(dg[0]);
         end
      end else begin
         if (d.ovf) begin
            f[0] = CH_STAR;
            f[1] = CH_STAR;
            f[2] = CH_STAR;
            f[3] = CH_POINT;
            f[4] = CH_STAR;
            f[5] = CH_STAR;
         end else begin
            // leading zeros blanked, units digit always shown
            f[0] = (dg[4] == 4'd0) ? CH_BLANK : digit_char(dg[4]);
            f[1] = (dg[4] == 4'd0 && dg[3] == 4'd0) ? CH_BLANK : digit_char(dg[3]);
            f[2] = digit_char(dg[2]);
            f[3] = CH_POINT;
            f[4] = digit_char(dg[1]);
            f[5] = digit_char(dg[0]);
         end
      end
      return f;
   endfunction

endpackage

@@ src/fpaf_dabble_cell.sv @@
// one cell of the binary to bcd conversion chain
module fpaf_dabble_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  fpaf_pkg::cell_data_type in_data,
   output logic                  out_valid,
   output fpaf_pkg::cell_data_type out_data
);
   import fpaf_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;

   // shift one binary bit into the digits
   always_comb begin
      data_in = dabble_step(in_data);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/fpaf_serializer.sv @@
// character shift register that hands out the six characters of a word
module fpaf_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   input  fpaf_pkg::cell_data_type       load_data,
   output logic                          load_take,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fpaf_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic [fpaf_pkg::POS_W-1:0]    rsp_char_position,
   output logic                          rsp_last_char
);
   import fpaf_pkg::*;

   field_type          char_ff;
   field_type          char_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               valid_ff;
   logic               valid_in;
   logic               rsp_take;
   logic               is_last;

   assign is_last   = (pos_ff == POS_W'(FIELD_LEN - 1));
   assign rsp_take  = valid_ff && !rsp_stall;
   // a new word enters when empty or as the last character leaves
   assign load_take = load_valid && (!valid_ff || (rsp_take && is_last));

   // next state of the character row
   always_comb begin
      char_in  = char_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load_take) begin
         char_in  = format_field(load_data);
         pos_in   = '0;
         valid_in = 1'b1;
      end else if (rsp_take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            char_in = {CH_BLANK, char_ff[FIELD_LEN-1:1]};
            pos_in  = pos_ff + POS_W'(1);
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   // characters
   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_char_code     = char_ff[0];
   assign rsp_char_position = pos_ff;
   assign rsp_last_char     = is_last;

   // position steps by one per character taken
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !is_last |=> valid_ff && pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("character position did not advance");

   // position never beyond the field
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> pos_ff <= POS_W'(FIELD_LEN - 1))
      else $error("character position out of range");

   // row empties after the last character when nothing waits
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_take && is_last && !load_valid |=> !valid_ff)
      else $error("word repeated after last character");

endmodule

@@ src/fixed_point_ascii_formatter_top.sv @@
// fixed-point to decimal ascii formatter, top level
// a word passes the prepare stage, the conversion cells and a load into the character row
// (one prepare stage, seventeen conversion cells, one load into the character row)
// the character row gives one character a cycle while rsp_stall is low, and so sets the word rate
// the chain accepts a new word each cycle unless its last word waits for the row, holding up to 18 words
// reset: synchronous, clears all valid bits and sets format_mode to unsigned hundredths
module fixed_point_ascii_formatter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fpaf_pkg::MODE_W-1:0]    csr_format_mode,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fpaf_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fpaf_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic [fpaf_pkg::POS_W-1:0]     rsp_char_position,
   output logic                           rsp_last_char
);
   import fpaf_pkg::*;

   logic [MODE_W-1:0]   mode_ff;
   logic [VALUE_W-1:0]  mag;
   logic [BIN_W-1:0]    ubin_int;
   logic [14:0]         ubin_frac_prod;
   cell_data_type       prep_in;
   cell_data_type       prep_data_ff;
   logic                prep_valid_ff;
   logic                adv;
   logic                ser_take;
   logic [CHAIN_LEN:0]  chain_valid;
   cell_data_type       chain_data [CHAIN_LEN+1];

   // format register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UDEC;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_format_mode;
      end
   end

   // chain moves unless its last word waits for the character row
   assign adv       = !(chain_valid[CHAIN_LEN] && !ser_take);
   assign req_stall = !adv;

   // range check and scaling into one binary number, below 100000 when in range
   always_comb begin
      mag            = req_value[VALUE_W-1] ? (~req_value + 32'd1) : req_value;
      ubin_int       = {7'd0, req_value[17:8]} * UBIN_INT_SCALE;
      ubin_frac_prod = {7'd0, req_value[7:0]} * {8'd0, FRAC_SCALE};
      prep_in.bcd    = '0;
      prep_in.neg    = 1'b0;
      prep_in.sdec   = 1'b0;
      case (mode_ff)
         MODE_SDEC: begin
            prep_in.bin  = mag[BIN_W-1:0];
            prep_in.ovf  = mag > SDEC_MAX;
            prep_in.neg  = req_value[VALUE_W-1];
            prep_in.sdec = 1'b1;
         end
         MODE_UBIN: begin
            prep_in.bin = ubin_int + {10'd0, ubin_frac_prod[14:8]};
            prep_in.ovf = req_value >= UBIN_LIMIT;
         end
         default: begin
            prep_in.bin = req_value[BIN_W-1:0];
            prep_in.ovf = req_value > UDEC_MAX;
         end
      endcase
   end

   // prepare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_data_ff <= prep_in;
      end
   end

   assign chain_valid[0] = prep_valid_ff;
   assign chain_data[0]  = prep_data_ff;

   // conversion chain, one binary bit per cell
   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
      fpaf_dabble_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // character row
   fpaf_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (chain_valid[CHAIN_LEN]),
      .load_data         (chain_data[CHAIN_LEN]),
      .load_take         (ser_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_code     (rsp_char_code),
      .rsp_char_position (rsp_char_position),
      .rsp_last_char     (rsp_last_char)
   );

   // a word held at the chain end stays until the row takes it
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      chain_valid[CHAIN_LEN] && !ser_take |=>
         chain_valid[CHAIN_LEN] && $stable(chain_data[CHAIN_LEN]))
      else $error("word lost at end of conversion chain");

endmodule
